// ----- rtl/pos_pkg.sv -----
package pos_pkg;

  localparam logic [0:0] CFG_MIN_DEPTH = 1'b0;
  localparam logic [0:0] CFG_PUSH_GAIN = 1'b1;

  localparam logic [15:0] MIN_DEPTH_RESET = 16'd26;
  localparam logic [9:0]  PUSH_GAIN_RESET = 10'd282;

  typedef struct packed {
    logic               action;
    logic signed [23:0] a_x;
    logic signed [23:0] a_y;
    logic [19:0]        a_radius;
    logic [15:0]        a_inv_mass;
    logic signed [23:0] b_x;
    logic signed [23:0] b_y;
    logic [19:0]        b_radius;
    logic signed [23:0] b_end_x;
    logic signed [23:0] b_end_y;
    logic [20:0]        speed_margin;
    logic [15:0]        b_inv_mass;
  } in_word_t;

  typedef struct packed {
    logic               connected;
    logic               corrected;
    logic signed [23:0] a_new_x;
    logic signed [23:0] a_new_y;
    logic signed [23:0] b_new_x;
    logic signed [23:0] b_new_y;
  } out_word_t;

endpackage

// ----- rtl/pos_in_if.sv -----
interface pos_in_if;
  logic               valid;
  logic               ready;
  pos_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/pos_out_if.sv -----
interface pos_out_if;
  logic               valid;
  logic               ready;
  pos_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/pair_overlap_separation.sv -----
// Overlap correction for one pair of objects per word, circle-circle or
// circle against a segment.
// Pair words arrive on the pair channel and result words leave on the
// result channel, both valid/ready; a word moves when valid and ready are
// high at a rising clock edge. Configuration is written through cfg_we,
// cfg_index and cfg_data while the block is idle.
// Every pair word gives exactly one result word. A new pair word is taken
// whenever pair.ready is high, so throughput is one word per cycle while the
// receiver does not stall; this is set by the rows of divider and square
// root cells, each retiring one quotient or root bit per cell per cycle.
// The result register holds its word while the receiver stalls; the
// pipeline keeps moving until a valid word reaches its last stage, and only
// then is pair.ready lowered.
// Reset empties the pipeline and loads min_overlap_depth with 26 and
// push_gain with 282.
module pair_overlap_separation (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  pos_in_if.sink      pair,
  pos_out_if.source   result
);

  typedef struct packed {
    logic               seg;
    logic signed [23:0] ax;
    logic signed [23:0] ay;
    logic signed [23:0] bx;
    logic signed [23:0] by;
    logic signed [23:0] ex;
    logic signed [23:0] ey;
    logic [15:0]        ia;
    logic [15:0]        ib;
    logic [20:0]        rng;
    logic [22:0]        conn;
    logic               box_ok;
    logic signed [24:0] abx;
    logic signed [24:0] aby;
    logic signed [24:0] pax;
    logic signed [24:0] pay;
    logic signed [49:0] p1;
    logic signed [49:0] p2;
    logic [48:0]        p3;
    logic [48:0]        p4;
    logic [45:0]        conn_sq;
    logic [45:0]        rng_sq;
    logic signed [51:0] n;
    logic [48:0]        d;
    logic               inner;
    logic signed [24:0] cx;
    logic signed [24:0] cy;
    logic signed [49:0] ptx;
    logic signed [49:0] pty;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic [49:0]        dxx;
    logic [49:0]        dyy;
    logic               connected;
    logic               near;
    logic [41:0]        sx;
    logic [20:0]        dlen;
    logic [21:0]        overlap;
    logic [16:0]        msum;
    logic               corr;
    logic [30:0]        og;
    logic [23:0]        depth;
    logic [39:0]        nua;
    logic [39:0]        nub;
    logic [23:0]        sa;
    logic [23:0]        sb;
    logic signed [49:0] mxa;
    logic signed [49:0] mya;
    logic signed [49:0] mxb;
    logic signed [49:0] myb;
    logic [45:0]        nxa;
    logic [45:0]        nya;
    logic [45:0]        nxb;
    logic [45:0]        nyb;
  } ctx_t;

  function automatic logic signed [24:0] round_q24(input logic signed [49:0] p);
    logic [49:0] mag;
    logic [49:0] sum;
    logic [24:0] q;
    mag = p[49] ? 50'(-p) : 50'(p);
    sum = mag + 50'd8388608;
    q   = sum[48:24];
    return p[49] ? $signed(-q) : $signed(q);
  endfunction

  function automatic logic [45:0] mag_num(input logic signed [49:0] p,
                                          input logic [20:0] dv);
    logic [49:0] mag;
    logic [49:0] sum;
    mag = p[49] ? 50'(-p) : 50'(p);
    sum = mag + {30'd0, dv[20:1]};
    return sum[45:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
    if (v > 26'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -26'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  function automatic logic signed [25:0] signed_q(input logic [23:0] q,
                                                  input logic neg);
    logic signed [25:0] v;
    v = $signed({2'b00, q});
    return neg ? -v : v;
  endfunction

  logic [15:0] min_overlap_depth;
  logic [9:0]  push_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_overlap_depth <= pos_pkg::MIN_DEPTH_RESET;
      push_gain         <= pos_pkg::PUSH_GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pos_pkg::CFG_MIN_DEPTH: min_overlap_depth <= cfg_data;
        pos_pkg::CFG_PUSH_GAIN: push_gain <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_v;
  pos_pkg::out_word_t out_w;

  ctx_t r_a, r_b, r_c, r_e, r_f, r_g, r_h, r_k, r_l, r_m, r_n, r_p;
  ctx_t nx_a, nx_b, nx_c, nx_d, nx_e, nx_f, nx_g, nx_h, nx_i;
  ctx_t nx_k, nx_l, nx_m, nx_n, nx_o, nx_p, nx_q;
  ctx_t ln_t [0:24];
  ctx_t ln_s [0:21];
  ctx_t ln_m [0:24];
  ctx_t ln_q [0:24];
  logic va, vb, vc, ve, vf, vg, vh, vk, vl, vm, vn, vp;
  logic vt [0:24];
  logic vs [0:21];
  logic vmq [0:24];
  logic vq [0:24];

  logic [23:0] t_q;
  logic [20:0] dist_q;
  logic [23:0] sa_q, sb_q;
  logic [23:0] qxa, qya, qxb, qyb;
  pos_pkg::out_word_t nx_out;

  assign en           = !vq[24] || !out_v || result.ready;
  assign pair.ready   = en;
  assign result.valid = out_v;
  assign result.data  = out_w;

  always_comb begin
    logic signed [23:0] lox, loy, hix, hiy;
    logic signed [25:0] axe, aye, ce;
    pos_pkg::in_word_t w;
    w    = pair.data;
    nx_a = '0;
    nx_a.seg = w.action;
    nx_a.ax  = w.a_x;
    nx_a.ay  = w.a_y;
    nx_a.bx  = w.b_x;
    nx_a.by  = w.b_y;
    nx_a.ex  = w.b_end_x;
    nx_a.ey  = w.b_end_y;
    nx_a.ia  = w.a_inv_mass;
    nx_a.ib  = w.b_inv_mass;
    nx_a.rng = w.action ? {1'b0, w.a_radius}
                        : {1'b0, w.a_radius} + {1'b0, w.b_radius};
    nx_a.conn = {2'b00, nx_a.rng} + {2'b00, w.speed_margin};
    lox = (w.b_x < w.b_end_x) ? w.b_x : w.b_end_x;
    hix = (w.b_x < w.b_end_x) ? w.b_end_x : w.b_x;
    loy = (w.b_y < w.b_end_y) ? w.b_y : w.b_end_y;
    hiy = (w.b_y < w.b_end_y) ? w.b_end_y : w.b_y;
    axe = 26'(w.a_x);
    aye = 26'(w.a_y);
    ce  = $signed({3'b000, nx_a.conn});
    nx_a.box_ok = !w.action ||
                  ((axe > 26'(lox) - ce) && (aye > 26'(loy) - ce) &&
                   (axe <= 26'(hix) + ce) && (aye <= 26'(hiy) + ce));
    nx_a.abx = 25'(w.b_end_x) - 25'(w.b_x);
    nx_a.aby = 25'(w.b_end_y) - 25'(w.b_y);
    nx_a.pax = 25'(w.a_x) - 25'(w.b_x);
    nx_a.pay = 25'(w.a_y) - 25'(w.b_y);
  end

  always_comb begin
    logic signed [49:0] sq3, sq4;
    logic [41:0] rsq;
    nx_b = r_a;
    nx_b.p1 = r_a.pax * r_a.abx;
    nx_b.p2 = r_a.pay * r_a.aby;
    sq3 = r_a.abx * r_a.abx;
    sq4 = r_a.aby * r_a.aby;
    nx_b.p3 = sq3[48:0];
    nx_b.p4 = sq4[48:0];
    nx_b.conn_sq = r_a.conn * r_a.conn;
    rsq = r_a.rng * r_a.rng;
    nx_b.rng_sq = {4'b0000, rsq};
  end

  always_comb begin
    nx_c = r_b;
    nx_c.n = 52'(r_b.p1) + 52'(r_b.p2);
    nx_c.d = r_b.p3 + r_b.p4;
  end

  always_comb begin
    nx_d = r_c;
    nx_d.inner = 1'b0;
    nx_d.cx = 25'(r_c.bx);
    nx_d.cy = 25'(r_c.by);
    if (r_c.seg && r_c.d != '0 && !r_c.n[51] && r_c.n != '0) begin
      if (r_c.n >= $signed({3'b000, r_c.d})) begin
        nx_d.cx = 25'(r_c.ex);
        nx_d.cy = 25'(r_c.ey);
      end else begin
        nx_d.inner = 1'b1;
      end
    end
  end

  pos_div_row #(.DEN_W(49), .STEPS(24)) u_div_t (
    .clk (clk),
    .en  (en),
    .den (ln_t[0].d),
    .rem (ln_t[0].inner ? ln_t[0].n[48:0] : 49'd0),
    .low (24'd0),
    .q   (t_q)
  );

  always_comb begin
    nx_e = ln_t[24];
    nx_e.ptx = ln_t[24].abx * $signed({1'b0, t_q});
    nx_e.pty = ln_t[24].aby * $signed({1'b0, t_q});
  end

  always_comb begin
    nx_f = r_e;
    if (r_e.inner) begin
      nx_f.cx = 25'(r_e.bx) + round_q24(r_e.ptx);
      nx_f.cy = 25'(r_e.by) + round_q24(r_e.pty);
    end
  end

  always_comb begin
    nx_g = r_f;
    nx_g.dx = r_f.cx - 25'(r_f.ax);
    nx_g.dy = r_f.cy - 25'(r_f.ay);
  end

  always_comb begin
    logic signed [49:0] sxx, syy;
    nx_h = r_g;
    sxx = r_g.dx * r_g.dx;
    syy = r_g.dy * r_g.dy;
    nx_h.dxx = sxx;
    nx_h.dyy = syy;
  end

  always_comb begin
    logic [49:0] dsq;
    nx_i = r_h;
    dsq = r_h.dxx + r_h.dyy;
    nx_i.connected = r_h.box_ok && (dsq < {4'b0000, r_h.conn_sq});
    nx_i.near = nx_i.connected && (dsq < {4'b0000, r_h.rng_sq});
    nx_i.sx = nx_i.near ? dsq[41:0] : 42'd0;
  end

  logic [41:0] sq_x    [0:21];
  logic [22:0] sq_rem  [0:21];
  logic [20:0] sq_root [0:21];

  assign sq_x[0]    = ln_s[0].sx;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign dist_q     = sq_root[21];

  for (genvar k = 0; k < 21; k++) begin : g_sqrt
    pos_sqrt_cell #(.ROOT_W(21)) u_cell (
      .clk      (clk),
      .en       (en),
      .x_in     (sq_x[k]),
      .rem_in   (sq_rem[k]),
      .root_in  (sq_root[k]),
      .x_out    (sq_x[k+1]),
      .rem_out  (sq_rem[k+1]),
      .root_out (sq_root[k+1])
    );
  end

  always_comb begin
    nx_k = ln_s[21];
    nx_k.dlen = dist_q;
    nx_k.overlap = {1'b0, ln_s[21].rng} - {1'b0, dist_q};
    nx_k.msum = {1'b0, ln_s[21].ia} + {1'b0, ln_s[21].ib};
    nx_k.corr = ln_s[21].near && (dist_q != '0) && (nx_k.msum != '0) &&
                (nx_k.overlap > {6'd0, min_overlap_depth});
  end

  always_comb begin
    nx_l = r_k;
    nx_l.og = r_k.overlap[20:0] * push_gain;
  end

  always_comb begin
    logic [31:0] s;
    nx_m = r_l;
    s = {1'b0, r_l.og} + 32'd128;
    nx_m.depth = s[31:8];
  end

  always_comb begin
    nx_n = r_m;
    nx_n.nua = r_m.depth * r_m.ia;
    nx_n.nub = r_m.depth * r_m.ib;
  end

  always_comb begin
    nx_o = r_n;
    nx_o.nua = r_n.nua + {24'd0, r_n.msum[16:1]};
    nx_o.nub = r_n.nub + {24'd0, r_n.msum[16:1]};
  end

  pos_div_row #(.DEN_W(17), .STEPS(24)) u_div_sa (
    .clk (clk),
    .en  (en),
    .den (ln_m[0].msum),
    .rem ({1'b0, ln_m[0].nua[39:24]}),
    .low (ln_m[0].nua[23:0]),
    .q   (sa_q)
  );

  pos_div_row #(.DEN_W(17), .STEPS(24)) u_div_sb (
    .clk (clk),
    .en  (en),
    .den (ln_m[0].msum),
    .rem ({1'b0, ln_m[0].nub[39:24]}),
    .low (ln_m[0].nub[23:0]),
    .q   (sb_q)
  );

  always_comb begin
    nx_p = ln_m[24];
    nx_p.sa  = sa_q;
    nx_p.sb  = sb_q;
    nx_p.mxa = ln_m[24].dx * $signed({1'b0, sa_q});
    nx_p.mya = ln_m[24].dy * $signed({1'b0, sa_q});
    nx_p.mxb = ln_m[24].dx * $signed({1'b0, sb_q});
    nx_p.myb = ln_m[24].dy * $signed({1'b0, sb_q});
  end

  always_comb begin
    nx_q = r_p;
    nx_q.nxa = mag_num(r_p.mxa, r_p.dlen);
    nx_q.nya = mag_num(r_p.mya, r_p.dlen);
    nx_q.nxb = mag_num(r_p.mxb, r_p.dlen);
    nx_q.nyb = mag_num(r_p.myb, r_p.dlen);
  end

  pos_div_row #(.DEN_W(21), .STEPS(24)) u_div_xa (
    .clk (clk), .en (en), .den (ln_q[0].dlen),
    .rem (ln_q[0].nxa[44:24]), .low (ln_q[0].nxa[23:0]), .q (qxa)
  );

  pos_div_row #(.DEN_W(21), .STEPS(24)) u_div_ya (
    .clk (clk), .en (en), .den (ln_q[0].dlen),
    .rem (ln_q[0].nya[44:24]), .low (ln_q[0].nya[23:0]), .q (qya)
  );

  pos_div_row #(.DEN_W(21), .STEPS(24)) u_div_xb (
    .clk (clk), .en (en), .den (ln_q[0].dlen),
    .rem (ln_q[0].nxb[44:24]), .low (ln_q[0].nxb[23:0]), .q (qxb)
  );

  pos_div_row #(.DEN_W(21), .STEPS(24)) u_div_yb (
    .clk (clk), .en (en), .den (ln_q[0].dlen),
    .rem (ln_q[0].nyb[44:24]), .low (ln_q[0].nyb[23:0]), .q (qyb)
  );

  always_comb begin
    ctx_t c;
    c = ln_q[24];
    nx_out.connected = c.connected;
    nx_out.corrected = c.corr;
    nx_out.a_new_x = c.ax;
    nx_out.a_new_y = c.ay;
    nx_out.b_new_x = c.bx;
    nx_out.b_new_y = c.by;
    if (c.corr) begin
      nx_out.a_new_x = sat24(26'(c.ax) - signed_q(qxa, c.mxa[49]));
      nx_out.a_new_y = sat24(26'(c.ay) - signed_q(qya, c.mya[49]));
      nx_out.b_new_x = sat24(26'(c.bx) + signed_q(qxb, c.mxb[49]));
      nx_out.b_new_y = sat24(26'(c.by) + signed_q(qyb, c.myb[49]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_a     <= nx_a;
      r_b     <= nx_b;
      r_c     <= nx_c;
      ln_t[0] <= nx_d;
      for (int k = 1; k <= 24; k++) begin
        ln_t[k] <= ln_t[k-1];
      end
      r_e     <= nx_e;
      r_f     <= nx_f;
      r_g     <= nx_g;
      r_h     <= nx_h;
      ln_s[0] <= nx_i;
      for (int k = 1; k <= 21; k++) begin
        ln_s[k] <= ln_s[k-1];
      end
      r_k     <= nx_k;
      r_l     <= nx_l;
      r_m     <= nx_m;
      r_n     <= nx_n;
      ln_m[0] <= nx_o;
      for (int k = 1; k <= 24; k++) begin
        ln_m[k] <= ln_m[k-1];
      end
      r_p     <= nx_p;
      ln_q[0] <= nx_q;
      for (int k = 1; k <= 24; k++) begin
        ln_q[k] <= ln_q[k-1];
      end
    end
    if (!out_v || result.ready) begin
      out_w <= nx_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; vb <= 1'b0; vc <= 1'b0; ve <= 1'b0; vf <= 1'b0;
      vg <= 1'b0; vh <= 1'b0; vk <= 1'b0; vl <= 1'b0; vm <= 1'b0;
      vn <= 1'b0; vp <= 1'b0;
      for (int k = 0; k <= 24; k++) begin
        vt[k]  <= 1'b0;
        vmq[k] <= 1'b0;
        vq[k]  <= 1'b0;
      end
      for (int k = 0; k <= 21; k++) begin
        vs[k] <= 1'b0;
      end
      out_v <= 1'b0;
    end else begin
      if (en) begin
        va    <= pair.valid;
        vb    <= va;
        vc    <= vb;
        vt[0] <= vc;
        for (int k = 1; k <= 24; k++) begin
          vt[k] <= vt[k-1];
        end
        ve    <= vt[24];
        vf    <= ve;
        vg    <= vf;
        vh    <= vg;
        vs[0] <= vh;
        for (int k = 1; k <= 21; k++) begin
          vs[k] <= vs[k-1];
        end
        vk     <= vs[21];
        vl     <= vk;
        vm     <= vl;
        vn     <= vm;
        vmq[0] <= vn;
        for (int k = 1; k <= 24; k++) begin
          vmq[k] <= vmq[k-1];
        end
        vp    <= vmq[24];
        vq[0] <= vp;
        for (int k = 1; k <= 24; k++) begin
          vq[k] <= vq[k-1];
        end
      end
      if (!out_v || result.ready) begin
        out_v <= vq[24];
      end
    end
  end

endmodule

// ----- rtl/pos_div_cell.sv -----
module pos_div_cell #(
  parameter int DEN_W = 17,
  parameter int LOW_W = 24
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DEN_W-1:0] den_in,
  input  logic [DEN_W-1:0] rem_in,
  input  logic [LOW_W-1:0] low_in,
  input  logic [LOW_W-1:0] q_in,
  output logic [DEN_W-1:0] den_out,
  output logic [DEN_W-1:0] rem_out,
  output logic [LOW_W-1:0] low_out,
  output logic [LOW_W-1:0] q_out
);

  logic [DEN_W:0] r2;
  logic [DEN_W:0] diff;
  logic           ge;

  always_comb begin
    r2   = {rem_in, low_in[LOW_W-1]};
    diff = r2 - {1'b0, den_in};
    ge   = (r2 >= {1'b0, den_in});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_out <= den_in;
      rem_out <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
      low_out <= {low_in[LOW_W-2:0], 1'b0};
      q_out   <= {q_in[LOW_W-2:0], ge};
    end
  end

endmodule

// ----- rtl/pos_div_row.sv -----
module pos_div_row #(
  parameter int DEN_W = 17,
  parameter int STEPS = 24
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DEN_W-1:0] den,
  input  logic [DEN_W-1:0] rem,
  input  logic [STEPS-1:0] low,
  output logic [STEPS-1:0] q
);

  logic [DEN_W-1:0] den_s [0:STEPS];
  logic [DEN_W-1:0] rem_s [0:STEPS];
  logic [STEPS-1:0] low_s [0:STEPS];
  logic [STEPS-1:0] q_s   [0:STEPS];

  assign den_s[0] = den;
  assign rem_s[0] = rem;
  assign low_s[0] = low;
  assign q_s[0]   = '0;
  assign q        = q_s[STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    pos_div_cell #(.DEN_W(DEN_W), .LOW_W(STEPS)) u_cell (
      .clk     (clk),
      .en      (en),
      .den_in  (den_s[k]),
      .rem_in  (rem_s[k]),
      .low_in  (low_s[k]),
      .q_in    (q_s[k]),
      .den_out (den_s[k+1]),
      .rem_out (rem_s[k+1]),
      .low_out (low_s[k+1]),
      .q_out   (q_s[k+1])
    );
  end

endmodule

// ----- rtl/pos_sqrt_cell.sv -----
module pos_sqrt_cell #(
  parameter int ROOT_W = 21
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [2*ROOT_W-1:0]   x_in,
  input  logic [ROOT_W+1:0]     rem_in,
  input  logic [ROOT_W-1:0]     root_in,
  output logic [2*ROOT_W-1:0]   x_out,
  output logic [ROOT_W+1:0]     rem_out,
  output logic [ROOT_W-1:0]     root_out
);

  logic [ROOT_W+3:0] r2;
  logic [ROOT_W+3:0] trial;
  logic [ROOT_W+3:0] diff;
  logic              ge;

  always_comb begin
    r2    = {rem_in, x_in[2*ROOT_W-1:2*ROOT_W-2]};
    trial = {2'b00, root_in, 2'b01};
    diff  = r2 - trial;
    ge    = (r2 >= trial);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out    <= {x_in[2*ROOT_W-3:0], 2'b00};
      rem_out  <= ge ? diff[ROOT_W+1:0] : r2[ROOT_W+1:0];
      root_out <= {root_in[ROOT_W-2:0], ge};
    end
  end

endmodule
